// ===== sv/gww_pkg.sv =====
// ----------------------------------------------------------------------------
// gww_pkg
// Types and constants shared by the greedy word wrapper.
// ----------------------------------------------------------------------------
`default_nettype none

package gww_pkg;

   localparam int BYTE_W = 8;
   // Wide enough for column + separator + word length without wrapping
   localparam int SUM_W  = 10;

   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
   localparam logic [BYTE_W-1:0] CH_CR      = 8'd13;
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;

   localparam logic [BYTE_W-1:0] WIDTH_RESET = 8'd80;

   localparam int           CSR_ADDR_W      = 2;
   localparam logic [1:0]   ADDR_LINE_WIDTH = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NL_PRE,
      ST_SPACE,
      ST_BYTES,
      ST_NL_PIECE,
      ST_NL_FINAL
   } state_type;

   function automatic logic is_space(input logic [BYTE_W-1:0] b);
      return ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_SPACE);
   endfunction

endpackage

`default_nettype wire

// ===== sv/gww_ram.sv =====
// ----------------------------------------------------------------------------
// gww_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 24,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/greedy_word_wrap_top.sv =====
// ----------------------------------------------------------------------------
// greedy_word_wrap_top
// Greedy word wrapper with splitting of words longer than the line width.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel as a kind bit and a text byte. A text
// byte that is not whitespace is written to the word RAM and causes no
// response. Whitespace or end of text starts the write-out of the buffered
// word on the rsp_ channel: one response per cycle while rsp_stall is low,
// each word byte read from the RAM in the cycle before it is sent, plus one
// response for every space or newline; end of text adds the final newline.
// The last response of a request carries rsp_last.
// req_stall is high while a word is being written out. Responses leave
// through an output register, so a new request is taken while the final
// response still waits. While rsp_stall is high the write-out pauses.
// Reset empties the word, sets the column to zero and the line width to 80;
// there is no clearing pass. line_width is written through the APB port at
// address 0; the user must write it only while the block is idle, as the
// block itself does not enforce this. A width of zero acts as one.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_word_wrap_top #(
   parameter int MAX_WORD = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_kind,
   input  wire logic [gww_pkg::BYTE_W-1:0]             req_text_byte,
   // response channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic      [gww_pkg::BYTE_W-1:0]             rsp_out_byte,
   output logic                                        rsp_last,
   output logic                                        rsp_truncated,
   // configuration port
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [gww_pkg::CSR_ADDR_W-1:0]         paddr,
   input  wire logic [31:0]                            pwdata,
   output logic      [31:0]                            prdata,
   output logic                                        pready
);

   import gww_pkg::*;

   localparam int LEN_W  = $clog2(MAX_WORD + 1);
   localparam int ADDR_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              piece_ff, piece_in;
   logic              eot_ff, eot_in;
   logic [BYTE_W-1:0] col_ff, col_in;
   logic              als_ff, als_in;
   logic              ov_ff, ov_in;
   logic [BYTE_W-1:0] width_ff, width_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_trunc_ff, rsp_trunc_in;

   logic              req_accept;
   logic              out_free;
   logic [BYTE_W-1:0] eff_width;
   logic [LEN_W-1:0]  rem;
   logic              rem_long;
   logic [LEN_W-1:0]  span;
   logic              word_long;
   logic              needs_break;
   logic [SUM_W-1:0]  fit_sum;
   state_type         start_state;
   logic              csr_write;

   logic              ram_wr_en;
   logic [BYTE_W-1:0] ram_rd_data;

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready & (paddr == ADDR_LINE_WIDTH);
   assign width_in  = csr_write ? pwdata[BYTE_W-1:0] : width_ff;

   always_comb begin
      prdata = '0;
      if (paddr == ADDR_LINE_WIDTH) begin
         prdata = {{(32-BYTE_W){1'b0}}, width_ff};
      end
   end

   // ---------------------------------------------------------------------
   // Shared decisions
   // ---------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign eff_width = (width_ff == '0) ? BYTE_W'(1) : width_ff;
   assign rem       = len_ff - idx_ff;
   assign rem_long  = BYTE_W'(rem) > eff_width;
   // Where the rest is longer than the width, eff_width is below it and fits
   assign span      = rem_long ? LEN_W'(eff_width) : rem;
   assign word_long = BYTE_W'(len_ff) > eff_width;
   assign fit_sum   = SUM_W'(col_ff) + {{(SUM_W-1){1'b0}}, ~als_ff} + SUM_W'(len_ff);
   assign needs_break = fit_sum > SUM_W'(eff_width);

   always_comb begin
      if (word_long) begin
         start_state = (col_ff != '0) ? ST_NL_PRE : ST_BYTES;
      end else if (needs_break) begin
         start_state = ST_NL_PRE;
      end else if (!als_ff) begin
         start_state = ST_SPACE;
      end else begin
         start_state = ST_BYTES;
      end
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == KIND_END) begin
                  state_in = (len_ff == '0) ? ST_NL_FINAL : start_state;
               end else if (is_space(req_text_byte) && (len_ff != '0)) begin
                  state_in = start_state;
               end
            end
         end
         ST_NL_PRE, ST_SPACE: begin
            if (out_free) begin
               state_in = ST_BYTES;
            end
         end
         ST_BYTES: begin
            if (out_free && (cnt_ff == LEN_W'(1))) begin
               if (piece_ff) begin
                  state_in = ST_NL_PIECE;
               end else begin
                  state_in = eot_ff ? ST_NL_FINAL : ST_IDLE;
               end
            end
         end
         ST_NL_PIECE: begin
            if (out_free) begin
               if (rem != '0) begin
                  state_in = ST_BYTES;
               end else begin
                  state_in = eot_ff ? ST_NL_FINAL : ST_IDLE;
               end
            end
         end
         ST_NL_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath and responses
   // ---------------------------------------------------------------------
   always_comb begin
      len_in       = len_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      piece_in     = piece_ff;
      eot_in       = eot_ff;
      col_in       = col_ff;
      als_in       = als_ff;
      ov_in        = ov_ff;
      ram_wr_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               eot_in = (req_kind == KIND_END);
               if ((req_kind == KIND_TEXT) && !is_space(req_text_byte)) begin
                  if (len_ff < LEN_W'(MAX_WORD)) begin
                     ram_wr_en = 1'b1;
                     len_in    = len_ff + LEN_W'(1);
                  end else begin
                     ov_in = 1'b1;
                  end
               end
            end
         end
         ST_NL_PRE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = CH_NEWLINE;
               rsp_last_in  = 1'b0;
               rsp_trunc_in = 1'b0;
               col_in       = '0;
               als_in       = 1'b1;
            end
         end
         ST_SPACE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = CH_SPACE;
               rsp_last_in  = 1'b0;
               rsp_trunc_in = 1'b0;
               col_in       = col_ff + BYTE_W'(1);
               als_in       = 1'b0;
            end
         end
         ST_BYTES: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = ram_rd_data;
               rsp_last_in  = (cnt_ff == LEN_W'(1)) & ~piece_ff & ~eot_ff;
               rsp_trunc_in = ov_ff;
               idx_in       = idx_ff + LEN_W'(1);
               cnt_in       = cnt_ff - LEN_W'(1);
               col_in       = col_ff + BYTE_W'(1);
               als_in       = 1'b0;
            end
         end
         ST_NL_PIECE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = CH_NEWLINE;
               rsp_last_in  = (rem == '0) & ~eot_ff;
               rsp_trunc_in = 1'b0;
               col_in       = '0;
               als_in       = 1'b1;
            end
         end
         ST_NL_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = CH_NEWLINE;
               rsp_last_in  = 1'b1;
               rsp_trunc_in = 1'b0;
               col_in       = '0;
               als_in       = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // A new span is sized from what is left of the word
      if ((state_ff != ST_BYTES) && (state_in == ST_BYTES)) begin
         cnt_in   = span;
         piece_in = rem_long;
      end

      // Leaving a write-out empties the word and rewinds the read pointer
      if ((state_ff != ST_IDLE) && (state_in == ST_IDLE)) begin
         len_in = '0;
         ov_in  = 1'b0;
         idx_in = '0;
      end
   end

   // The read address follows the next pointer, so the data for the
   // current byte is always waiting at the RAM output.
   gww_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_WORD)
   ) u_word_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (len_ff[ADDR_W-1:0]),
      .wr_data    (req_text_byte),
      .rd_addr    (idx_in[ADDR_W-1:0]),
      .rd_data_ff (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         piece_ff     <= 1'b0;
         eot_ff       <= 1'b0;
         col_ff       <= '0;
         als_ff       <= 1'b1;
         ov_ff        <= 1'b0;
         width_ff     <= WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         piece_ff     <= piece_in;
         eot_ff       <= eot_in;
         col_ff       <= col_in;
         als_ff       <= als_in;
         ov_ff        <= ov_in;
         width_ff     <= width_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_truncated = rsp_trunc_ff;

`ifndef SYNTHESIS
   // The read pointer never runs past the buffered word.
   a_idx_in_word: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= len_ff)
      else $error("read pointer beyond the word length");

   // A span being written out always has bytes left.
   a_span_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BYTES) |-> (cnt_ff != '0))
      else $error("byte state with an empty span");

   // Overflow is only flagged once the word RAM is full.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> (len_ff == LEN_W'(MAX_WORD)))
      else $error("overflow flagged with room left in the word");

   // End of text leaves the wrapper at the start of an empty line.
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_NL_FINAL) && out_free) |=>
         ((state_ff == ST_IDLE) && (len_ff == '0) && (col_ff == '0) && als_ff && !ov_ff))
      else $error("end of text did not clear the state");

   // Every response other than the final newline of a request is not marked last
   // unless the write-out is returning to idle.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && rsp_last_in && (state_ff != ST_IDLE) && out_free) |->
         (state_in == ST_IDLE))
      else $error("last response while the write-out continues");
`endif

endmodule

`default_nettype wire
